### src/svpwm_pkg.sv
package svpwm_pkg;

	typedef logic [2:0] sector_t;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 56;
	localparam int DUTY_W = 16;

	localparam logic [31:0] SQRT3_Q30 = 32'd1859775393;
	localparam logic [31:0] INV_SQRT3_Q30 = 32'd619925131;

	localparam logic [DUTY_W-1:0] DUTY_FULL = 16'd32768;
	localparam logic [DUTY_W-1:0] DUTY_HALF = 16'd16384;

	localparam sector_t SEC_1 = 3'd1;
	localparam sector_t SEC_2 = 3'd2;
	localparam sector_t SEC_3 = 3'd3;
	localparam sector_t SEC_4 = 3'd4;
	localparam sector_t SEC_5 = 3'd5;
	localparam sector_t SEC_6 = 3'd6;

	// Projection sign codes: bit 0 beta, bit 1 sqrt3*alpha - beta, bit 2 -sqrt3*alpha - beta.
	localparam logic [2:0] CODE_SEC_1 = 3'd3;
	localparam logic [2:0] CODE_SEC_2 = 3'd1;
	localparam logic [2:0] CODE_SEC_3 = 3'd5;
	localparam logic [2:0] CODE_SEC_4 = 3'd4;
	localparam logic [2:0] CODE_SEC_5 = 3'd6;
	localparam logic [2:0] CODE_SEC_6 = 3'd2;

endpackage

### src/space_vector_pwm_duty_unit.sv
// Seven-segment, centre-aligned space vector PWM duty calculator. Each input word carries a
// signed Q1.15 alpha-beta voltage vector and each output word the three phase compare values
// (unsigned Q1.15, 32768 is the full period) and the sector 1 to 6; a vector with no sector
// gives three half-period duties and sector 1. The block accepts one word every clock cycle
// while its skid buffer is empty and returns results in order. The pipeline holds the
// overmodulation divider, a restoring array of FRAC_BITS + 3 one-bit stages, plus eight
// arithmetic stages and the output register. A two-word output buffer lets one further
// word enter while a result waits to be taken.
module space_vector_pwm_duty_unit #(
	parameter int FRAC_BITS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// v_alpha [15:0], v_beta [31:16]
	input  logic [svpwm_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// duty_u [15:0], duty_v [31:16], duty_w [47:32], sector_number [50:48], zero [55:51]
	output logic [svpwm_pkg::M_TDATA_W-1:0] m_tdata
);
	import svpwm_pkg::*;

	localparam int UP_SH = (FRAC_BITS >= 15) ? (FRAC_BITS - 15) : 0;
	localparam int DN_SH = (FRAC_BITS < 15) ? (15 - FRAC_BITS) : 0;
	localparam int HALF_DN = (1 << DN_SH) >> 1;
	localparam int HALF_UP = (1 << UP_SH) >> 1;
	localparam int AW = FRAC_BITS + 2;
	localparam int PW = 2 * FRAC_BITS + 4;
	localparam int WW = FRAC_BITS + 4;
	localparam int QW = FRAC_BITS + 3;
	localparam int NW = 2 * FRAC_BITS + 2;
	localparam int DW = WW + DN_SH + 1;
	localparam int CONST_SH = 30 - FRAC_BITS;
	localparam logic [63:0] C_HALF = (64'd1 << CONST_SH) >> 1;
	localparam logic [63:0] S3_64 = ({32'd0, SQRT3_Q30} + C_HALF) >> CONST_SH;
	localparam logic [63:0] IS3_64 = ({32'd0, INV_SQRT3_Q30} + C_HALF) >> CONST_SH;
	localparam logic signed [AW-1:0] S3_W = AW'(S3_64);
	localparam logic signed [AW-1:0] IS3_W = AW'(IS3_64);
	localparam logic signed [WW-1:0] WORK_ONE = WW'(1) << FRAC_BITS;
	localparam logic [PW-1:0] HALF_F = PW'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic signed [WW-1:0] ta;
		logic signed [WW-1:0] tb;
		logic signed [WW-1:0] sum;
		logic                 scaled;
		logic                 neg_a;
		logic                 neg_b;
		sector_t              sec;
		logic                 deg;
	} side_t;

	function automatic logic signed [AW-1:0] rescale_in(input logic [15:0] x);
		logic        neg;
		logic [16:0] mag;
		logic [16:0] rnd;
		logic [AW-1:0] sh;
		neg = x[15];
		mag = neg ? (17'd0 - {x[15], x}) : {1'b0, x};
		rnd = (mag + 17'(HALF_DN)) >> DN_SH;
		sh = AW'(rnd) << UP_SH;
		return neg ? (AW'(0) - sh) : sh;
	endfunction

	function automatic logic signed [WW-1:0] half_round(input logic signed [WW-1:0] v);
		logic [WW-1:0] mag;
		logic [WW-1:0] r;
		mag = (v < 0) ? (WW'(0) - v) : v;
		r = (mag + WW'(1)) >> 1;
		return (v < 0) ? (WW'(0) - r) : r;
	endfunction

	function automatic logic [DUTY_W-1:0] to_duty(input logic signed [WW-1:0] w);
		logic [DW-1:0] d;
		logic [DUTY_W-1:0] res;
		d = ((DW'(w) + DW'(HALF_UP)) >> UP_SH) << DN_SH;
		if (w < 0) begin
			res = '0;
		end else if (d > DW'(DUTY_FULL)) begin
			res = DUTY_FULL;
		end else begin
			res = d[DUTY_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [WW+QW-1:0] div_step(input logic [WW-1:0] r,
			input logic [QW-1:0] lq, input logic signed [WW-1:0] d);
		logic [WW:0] t;
		logic [WW:0] dd;
		logic        ge;
		t = {r, lq[QW-1]};
		dd = {1'b0, d};
		ge = (t >= dd);
		return {(ge ? WW'(t - dd) : WW'(t)), lq[QW-2:0], ge};
	endfunction

	logic adv;
	logic take;

	logic v_s1, v_s2, v_s3, v_s4, v_s6, v_s7, v_s8;
	logic signed [AW-1:0] a_s1, b_s1, a_s2, b_s2;
	logic signed [PW-1:0] pa_s2, pb_s2;
	logic signed [WW-1:0] a_s3, bs_s3;
	sector_t sec_s3, sec_s4, sec_s6, sec_s7, sec_s8;
	logic deg_s3, deg_s4, deg_s6, deg_s7;
	logic signed [WW-1:0] ta_s4, tb_s4, sum_s4;
	logic signed [WW-1:0] ta_s6, tb_s6, t0_s6;
	logic signed [WW-1:0] t0_s7, t1_s7, t2_s7;
	logic [DUTY_W-1:0] du_s8, dv_s8, dw_s8;

	// Divider stages: index 0 holds the set-up values, index QW the quotients.
	logic              dv_v_s   [0:QW];
	logic [WW-1:0]     dv_ra_s  [0:QW];
	logic [WW-1:0]     dv_rb_s  [0:QW];
	logic [QW-1:0]     dv_qa_s  [0:QW];
	logic [QW-1:0]     dv_qb_s  [0:QW];
	side_t             dv_sd_s  [0:QW];

	logic [M_TDATA_W-1:0] out_q, skid_q, p_word;
	logic out_v_q, skid_v_q;

	assign adv = !skid_v_q;
	assign s_tready = adv;
	assign take = out_v_q && m_tready;

	// Stage 1: rescale to the working format.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			dv_v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= rescale_in(s_tdata[15:0]);
			b_s1 <= rescale_in(s_tdata[31:16]);
		end
	end

	// Stage 2: the two constant products.
	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s2 <= PW'(a_s1) * PW'(S3_W);
			pb_s2 <= PW'(b_s1) * PW'(IS3_W);
			a_s2 <= a_s1;
			b_s2 <= b_s1;
		end
	end

	// Stage 3: sector from the projection signs, rounded beta / sqrt3.
	logic signed [PW-1:0] bsh, r2, r3;
	logic [PW-1:0] pb_mag, pb_rnd;
	logic [2:0] code;
	sector_t sec_d3;
	logic deg_d3;
	logic signed [WW-1:0] bs_d3;

	always_comb begin
		bsh = PW'(b_s2) <<< FRAC_BITS;
		r2 = pa_s2 - bsh;
		r3 = -pa_s2 - bsh;
		code = {r3 > 0, r2 > 0, b_s2 > 0};
		pb_mag = (pb_s2 < 0) ? (PW'(0) - pb_s2) : pb_s2;
		pb_rnd = (pb_mag + HALF_F) >> FRAC_BITS;
		bs_d3 = (pb_s2 < 0) ? WW'(PW'(0) - pb_rnd) : WW'(pb_rnd);
		deg_d3 = 1'b0;
		case (code)
			CODE_SEC_1: sec_d3 = SEC_1;
			CODE_SEC_2: sec_d3 = SEC_2;
			CODE_SEC_3: sec_d3 = SEC_3;
			CODE_SEC_4: sec_d3 = SEC_4;
			CODE_SEC_5: sec_d3 = SEC_5;
			CODE_SEC_6: sec_d3 = SEC_6;
			default: begin
				sec_d3 = SEC_1;
				deg_d3 = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3 <= WW'(a_s2);
			bs_s3 <= bs_d3;
			sec_s3 <= sec_d3;
			deg_s3 <= deg_d3;
		end
	end

	// Stage 4: active times from X, Y and Z.
	logic signed [WW-1:0] x_d, y_d, z_d, ta_d, tb_d;

	always_comb begin
		x_d = bs_s3 <<< 1;
		y_d = a_s3 + bs_s3;
		z_d = bs_s3 - a_s3;
		case (sec_s3)
			SEC_1: begin ta_d = x_d; tb_d = -z_d; end
			SEC_2: begin ta_d = y_d; tb_d = z_d; end
			SEC_3: begin ta_d = -y_d; tb_d = x_d; end
			SEC_4: begin ta_d = z_d; tb_d = -x_d; end
			SEC_5: begin ta_d = -z_d; tb_d = -y_d; end
			default: begin ta_d = -x_d; tb_d = y_d; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s4 <= ta_d;
			tb_s4 <= tb_d;
			sum_s4 <= ta_d + tb_d;
			sec_s4 <= sec_s3;
			deg_s4 <= deg_s3;
		end
	end

	// Stage 5: divider set-up with the rounding offset folded into the dividend.
	logic [WW-1:0] mag_a, mag_b;
	logic [NW-1:0] n_a, n_b, half_sum;
	side_t sd_d5;

	always_comb begin
		mag_a = (ta_s4 < 0) ? (WW'(0) - ta_s4) : ta_s4;
		mag_b = (tb_s4 < 0) ? (WW'(0) - tb_s4) : tb_s4;
		half_sum = NW'(sum_s4[WW-1:1]);
		n_a = (NW'(mag_a) << FRAC_BITS) + half_sum;
		n_b = (NW'(mag_b) << FRAC_BITS) + half_sum;
		sd_d5.ta = ta_s4;
		sd_d5.tb = tb_s4;
		sd_d5.sum = sum_s4;
		sd_d5.scaled = (sum_s4 > WORK_ONE);
		sd_d5.neg_a = (ta_s4 < 0);
		sd_d5.neg_b = (tb_s4 < 0);
		sd_d5.sec = sec_s4;
		sd_d5.deg = deg_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_ra_s[0] <= WW'(n_a >> QW);
			dv_rb_s[0] <= WW'(n_b >> QW);
			dv_qa_s[0] <= n_a[QW-1:0];
			dv_qb_s[0] <= n_b[QW-1:0];
			dv_sd_s[0] <= sd_d5;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_div
		logic [WW-1:0] ra_d, rb_d;
		logic [QW-1:0] qa_d, qb_d;

		always_comb begin
			{ra_d, qa_d} = div_step(dv_ra_s[k-1], dv_qa_s[k-1], dv_sd_s[k-1].sum);
			{rb_d, qb_d} = div_step(dv_rb_s[k-1], dv_qb_s[k-1], dv_sd_s[k-1].sum);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ra_s[k] <= ra_d;
				dv_rb_s[k] <= rb_d;
				dv_qa_s[k] <= qa_d;
				dv_qb_s[k] <= qb_d;
				dv_sd_s[k] <= dv_sd_s[k-1];
			end
		end
	end

	// Stage 6: signed quotients and the centred zero-vector time.
	side_t sd_q;
	logic signed [WW-1:0] qa_w, qb_w, ta_f, tb_f;

	always_comb begin
		sd_q = dv_sd_s[QW];
		qa_w = WW'(dv_qa_s[QW]);
		qb_w = WW'(dv_qb_s[QW]);
		ta_f = sd_q.scaled ? (sd_q.neg_a ? -qa_w : qa_w) : sd_q.ta;
		tb_f = sd_q.scaled ? (sd_q.neg_b ? -qb_w : qb_w) : sd_q.tb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s6 <= dv_v_s[QW];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s6 <= ta_f;
			tb_s6 <= tb_f;
			t0_s6 <= half_round(WORK_ONE - ta_f - tb_f);
			sec_s6 <= sd_q.sec;
			deg_s6 <= sd_q.deg;
		end
	end

	// Stage 7: switching instants.
	always_ff @(posedge clk) begin
		if (adv) begin
			t0_s7 <= t0_s6;
			t1_s7 <= t0_s6 + ta_s6;
			t2_s7 <= t0_s6 + ta_s6 + tb_s6;
			sec_s7 <= sec_s6;
			deg_s7 <= deg_s6;
		end
	end

	// Stage 8: assign instants to phases and scale to compare values.
	logic signed [WW-1:0] du_w, dv_w, dw_w;

	always_comb begin
		case (sec_s7)
			SEC_1: begin du_w = t2_s7; dv_w = t1_s7; dw_w = t0_s7; end
			SEC_2: begin du_w = t1_s7; dv_w = t2_s7; dw_w = t0_s7; end
			SEC_3: begin du_w = t0_s7; dv_w = t2_s7; dw_w = t1_s7; end
			SEC_4: begin du_w = t0_s7; dv_w = t1_s7; dw_w = t2_s7; end
			SEC_5: begin du_w = t1_s7; dv_w = t0_s7; dw_w = t2_s7; end
			default: begin du_w = t2_s7; dv_w = t0_s7; dw_w = t1_s7; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			du_s8 <= deg_s7 ? DUTY_HALF : to_duty(du_w);
			dv_s8 <= deg_s7 ? DUTY_HALF : to_duty(dv_w);
			dw_s8 <= deg_s7 ? DUTY_HALF : to_duty(dw_w);
			sec_s8 <= deg_s7 ? SEC_1 : sec_s7;
		end
	end

	assign p_word = {5'd0, sec_s8, dw_s8, dv_s8, du_s8};

	// Output register with a one-word skid buffer behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s8) begin
			if (!out_v_q || take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (v_s8) begin
			if (!out_v_q || take) begin
				out_q <= p_word;
			end else begin
				skid_q <= p_word;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

endmodule

### src/svpwm_duty_check.sv
module svpwm_duty_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [svpwm_pkg::M_TDATA_W-1:0] m_tdata
);
	import svpwm_pkg::*;

	sector_t sec;
	assign sec = m_tdata[50:48];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Output word changed or dropped while stalled.");

	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> sec >= SEC_1 && sec <= SEC_6)
		else $error("Sector outside 1 to 6.");

	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] <= DUTY_FULL && m_tdata[31:16] <= DUTY_FULL
			&& m_tdata[47:32] <= DUTY_FULL)
		else $error("Duty above full period.");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:51] == 5'd0)
		else $error("Padding bits of the output word are not zero.");

endmodule

bind space_vector_pwm_duty_unit svpwm_duty_check u_svpwm_duty_check (.*);
